### rtl/rtte_pkg.sv
// Shared types, codes and helpers for the retransmission timeout estimator.
package rtte_pkg;

  // Event codes carried in the action field
  typedef enum logic [1:0] {
    ACT_NEW_PACKET = 2'd0,
    ACT_SAMPLE     = 2'd1,
    ACT_TIMEOUT    = 2'd2
  } action_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_MIN_TIMEOUT   = 2'd0;
  localparam logic [1:0] CFG_MAX_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_MAX_REXMT     = 2'd2;

  localparam logic [15:0] RST_MIN_TIMEOUT  = 16'd1000;
  localparam logic [15:0] RST_MAX_TIMEOUT  = 16'd60000;
  localparam logic [3:0]  RST_MAX_REXMT    = 4'd3;

  localparam logic [15:0] RST_SRTT         = 16'd0;
  localparam logic [15:0] RST_RTTVAR       = 16'd750;
  // clamp of srtt + 4 * rttvar against the reset bounds
  localparam logic [15:0] RST_TIMEOUT      = 16'd3000;
  localparam logic [4:0]  REXMT_COUNT_MAX  = 5'd31;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] sample_ms;
  } in_item_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic        give_up;
  } out_item_t;

  typedef struct packed {
    logic [15:0] min_timeout_ms;
    logic [15:0] max_timeout_ms;
    logic [3:0]  max_retransmits;
  } cfg_t;

  // When the bounds cross, a value below the lower bound gives it; any other gives the upper bound.
  function automatic logic [15:0] clamp_timeout(logic [18:0] v, logic [15:0] lo,
                                                logic [15:0] hi);
    logic [15:0] r;
    priority if (v < {3'b000, lo}) begin
      r = lo;
    end else if (v > {3'b000, hi}) begin
      r = hi;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/rtte_cfg_regs.sv
// Configuration register file: clamp bounds and retransmit limit.
module rtte_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               cfg_ready_o,
  output rtte_pkg::cfg_t     cfg_o
);
  import rtte_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MIN_TIMEOUT: cfg_d.min_timeout_ms  = cfg_data_i;
        CFG_MAX_TIMEOUT: cfg_d.max_timeout_ms  = cfg_data_i;
        CFG_MAX_REXMT:   cfg_d.max_retransmits = cfg_data_i[3:0];
        default:         cfg_d = cfg_q; // drop writes to unknown indexes
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_timeout_ms  <= RST_MIN_TIMEOUT;
      cfg_q.max_timeout_ms  <= RST_MAX_TIMEOUT;
      cfg_q.max_retransmits <= RST_MAX_REXMT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/rtte_core.sv
// Estimator state and the single-pass update for one event.
module rtte_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  rtte_pkg::in_item_t    item_i,
  input  rtte_pkg::cfg_t        cfg_i,
  output rtte_pkg::out_item_t   result_o
);
  import rtte_pkg::*;

  logic [15:0] srtt_q, srtt_d;
  logic [15:0] rttvar_q, rttvar_d;
  logic [15:0] timeout_q, timeout_d;
  logic [4:0]  count_q, count_d;
  logic        give_up;

  logic signed [17:0] delta;
  logic [15:0]        delta_mag;
  logic [15:0]        srtt_upd;
  logic signed [17:0] var_diff;
  logic [15:0]        var_mag;
  logic [15:0]        rttvar_upd;
  logic [18:0]        estimate;

  // Sample path: shifts of the magnitude give truncation toward zero.
  always_comb begin
    delta     = $signed({2'b00, item_i.sample_ms}) - $signed({2'b00, srtt_q});
    delta_mag = delta[17] ? 16'(-delta) : delta[15:0];
    srtt_upd  = delta[17] ? srtt_q - (delta_mag >> 3) : srtt_q + (delta_mag >> 3);
    var_diff  = $signed({2'b00, delta_mag}) - $signed({2'b00, rttvar_q});
    var_mag   = var_diff[17] ? 16'(-var_diff) : var_diff[15:0];
    rttvar_upd = var_diff[17] ? rttvar_q - (var_mag >> 2) : rttvar_q + (var_mag >> 2);
    estimate  = {3'b000, srtt_upd} + {1'b0, rttvar_upd, 2'b00};
  end

  always_comb begin
    srtt_d    = srtt_q;
    rttvar_d  = rttvar_q;
    timeout_d = timeout_q;
    count_d   = count_q;
    give_up   = 1'b0;
    unique case (action_e'(item_i.action))
      ACT_NEW_PACKET: count_d = '0;
      ACT_SAMPLE: begin
        srtt_d    = srtt_upd;
        rttvar_d  = rttvar_upd;
        timeout_d = clamp_timeout(estimate, cfg_i.min_timeout_ms, cfg_i.max_timeout_ms);
      end
      ACT_TIMEOUT: begin
        timeout_d = clamp_timeout({2'b00, timeout_q, 1'b0}, cfg_i.min_timeout_ms,
                                  cfg_i.max_timeout_ms);
        // saturate the count
        count_d   = (count_q == REXMT_COUNT_MAX) ? count_q : count_q + 5'd1;
        give_up   = count_d > {1'b0, cfg_i.max_retransmits};
      end
      default: ; // unused code: hold everything
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srtt_q    <= RST_SRTT;
      rttvar_q  <= RST_RTTVAR;
      timeout_q <= RST_TIMEOUT;
      count_q   <= '0;
    end else if (step_i) begin
      srtt_q    <= srtt_d;
      rttvar_q  <= rttvar_d;
      timeout_q <= timeout_d;
      count_q   <= count_d;
    end
  end

  assign result_o.timeout_ms = timeout_d;
  assign result_o.give_up    = give_up;

  a_timeout_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == ACT_TIMEOUT |=> count_q != 5'd0)
    else $error("retransmit count zero after a timeout event");

  a_new_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && item_i.action == ACT_NEW_PACKET |=> count_q == 5'd0)
    else $error("retransmit count not cleared by a new packet");

  a_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (item_i.action == ACT_SAMPLE || item_i.action == ACT_TIMEOUT) &&
    cfg_i.min_timeout_ms <= cfg_i.max_timeout_ms
    |=> timeout_q >= $past(cfg_i.min_timeout_ms) &&
        timeout_q <= $past(cfg_i.max_timeout_ms))
    else $error("stored timeout outside the clamp bounds");

  a_give_up_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    give_up |-> item_i.action == ACT_TIMEOUT && count_d != 5'd0)
    else $error("give-up raised on a non-timeout event");

endmodule

### rtl/rtt_retransmit_timeout_estimator.sv
// Top level of the retransmission timeout estimator: input and result registers.
//
//   channel  | direction | handshake              | beat
//   ---------+-----------+------------------------+-------------------------------
//   in       | in        | in_valid_i / in_stall_o   | in_item_i (action, sample_ms)
//   out      | out       | out_valid_o / out_stall_i | out_item_o (timeout_ms, give_up)
//   cfg      | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// One event per cycle sustained while the output is not stalled; a beat passes
// from the input register through the update logic into the result register.
// Reset restores the estimator state and register defaults at once; no sweep.
// A stalled output holds the result register; the input register then fills and
// in_stall_o rises only while it holds a beat that cannot move on.
// Configuration writes are taken every cycle (cfg_ready_o is always high).
module rtt_retransmit_timeout_estimator (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rtte_pkg::in_item_t    in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rtte_pkg::out_item_t   out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [15:0]           cfg_data_i
);
  import rtte_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_q;
  logic      in_valid_q;
  out_item_t result, out_item_q;
  logic      out_valid_q;
  logic      step;

  rtte_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg)
  );

  // advance the held beat when the result register is free or draining
  assign step       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !step;

  rtte_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (step) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !in_stall_o)
    else $error("input stalled while the input register is empty");

  a_step_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("result register empty after a step");

  a_stall_keeps_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> in_valid_q && $stable(in_item_q))
    else $error("held input beat lost while stalled");

endmodule
